FILE: rtl/core/pica_pkg.sv
// Shared types and constants for the PI controller datapath.
package pica_pkg;

	localparam int GAIN_W    = 8;
	localparam int SAMPLE_W  = 10;
	localparam int ERR_W     = 10;
	localparam int PROD_W    = 20;
	localparam int MAG_W     = 19;
	localparam int QUOT_W    = 13;
	localparam int ACC_W     = 16;
	localparam int RECIP_W   = 13;
	localparam int DIVPROD_W = MAG_W + RECIP_W;

	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [QUOT_W-1:0] quot_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef enum logic [0:0] {
		REG_PROP_GAIN  = 1'b0,
		REG_INTEG_GAIN = 1'b1
	} reg_idx_t;

	localparam err_t ERR_MAX = 10'sd500;
	localparam err_t ERR_MIN = -10'sd500;

	localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
	localparam int                 RECIP_SHIFT = 19;
	localparam logic [6:0]         DIVISOR     = 7'd100;

	localparam acc_t DRIVE_MAX = 16'sd900;
	localparam acc_t ACC_RESET = 16'sd10;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd2;

endpackage

FILE: rtl/core/pica_div100.sv
// Two-stage signed divide by one hundred, truncating toward zero.
module pica_div100 (
	input  logic            clk,
	input  logic            en,
	input  pica_pkg::prod_t x,
	output pica_pkg::quot_t q
);
	import pica_pkg::*;

	logic [MAG_W-1:0]     mag;
	logic [DIVPROD_W-1:0] prod;
	logic [MAG_W-1:0]     mag_s1;
	logic [QUOT_W-1:0]    q0_s1;
	logic                 neg_s1;
	logic [PROD_W-1:0]    back;
	logic signed [PROD_W:0] rem;
	logic [QUOT_W-1:0]    qc;
	quot_t                q_s2;

	always_comb begin
		mag  = x[PROD_W-1] ? MAG_W'(-x) : MAG_W'(x);
		prod = DIVPROD_W'(mag) * DIVPROD_W'(RECIP_100);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag;
			q0_s1  <= prod[RECIP_SHIFT +: QUOT_W];
			neg_s1 <= x[PROD_W-1];
		end
	end

	always_comb begin
		back = PROD_W'(q0_s1) * PROD_W'(DIVISOR);
		rem  = $signed({2'b00, mag_s1}) - $signed({1'b0, back});
		qc   = (rem < 0) ? q0_s1 - QUOT_W'(1) : q0_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= neg_s1 ? -$signed(qc) : $signed(qc);
		end
	end

	assign q = q_s2;

endmodule

FILE: rtl/core/pi_controller_anti_windup.sv
// PI controller with clamped error and back-calculation anti-windup.
// A word passes the product registers, the divider stages and the output register in turn.
// Throughput: one word per cycle; the integral feedback closes in the last stage.
// The whole pipeline holds while a result waits on out_ready.
// Reset: gains return to 2, the integral to 10, all pipeline valids clear.
module pi_controller_anti_windup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [0:0]                      cfg_index,
	input  logic [pica_pkg::GAIN_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pica_pkg::SAMPLE_W-1:0]   setpoint,
	input  logic [pica_pkg::SAMPLE_W-1:0]   process_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pica_pkg::SAMPLE_W-1:0]   drive,
	output logic                            saturated
);
	import pica_pkg::*;

	logic [GAIN_W-1:0]   prop_gain_q;
	logic [GAIN_W-1:0]   integ_gain_q;
	acc_t                integral_q;
	logic                en;
	logic                v_s1, v_s2, v_s3;
	logic                out_valid_q;
	logic signed [SAMPLE_W:0] diff;
	err_t                err;
	logic [GAIN_W+1:0]   ki3;
	prod_t               ep, ip;
	prod_t               ep_s1, ip_s1;
	quot_t               p_s3, idiv_s3;
	acc_t                p_w, i_w, a_w;
	logic [SAMPLE_W-1:0] drive_q;
	logic                sat_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= GAIN_RESET;
			integ_gain_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		diff = $signed({1'b0, setpoint}) - $signed({1'b0, process_value});
		if (diff > $signed({ERR_MAX[ERR_W-1], ERR_MAX})) begin
			err = ERR_MAX;
		end else if (diff < $signed({ERR_MIN[ERR_W-1], ERR_MIN})) begin
			err = ERR_MIN;
		end else begin
			err = err_t'(diff);
		end
		ki3 = {2'b00, integ_gain_q} + {1'b0, integ_gain_q, 1'b0};
		ep  = PROD_W'(err) * PROD_W'($signed({1'b0, prop_gain_q}));
		ip  = PROD_W'(err) * PROD_W'($signed({1'b0, ki3}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ep_s1 <= ep;
			ip_s1 <= ip;
		end
	end

	pica_div100 u_div_p (
		.clk (clk),
		.en  (en),
		.x   (ep_s1),
		.q   (p_s3)
	);

	pica_div100 u_div_i (
		.clk (clk),
		.en  (en),
		.x   (ip_s1),
		.q   (idiv_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_comb begin
		p_w = ACC_W'(p_s3);
		i_w = ACC_W'(idiv_s3) + integral_q;
		a_w = p_w + i_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= ACC_RESET;
		end else if (en && v_s3) begin
			if (a_w > DRIVE_MAX) begin
				integral_q <= DRIVE_MAX - p_w;
			end else if (a_w < 0) begin
				integral_q <= -p_w;
			end else begin
				integral_q <= i_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			if (a_w > DRIVE_MAX) begin
				drive_q <= SAMPLE_W'(DRIVE_MAX);
				sat_q   <= 1'b1;
			end else if (a_w < 0) begin
				drive_q <= '0;
				sat_q   <= 1'b1;
			end else begin
				drive_q <= SAMPLE_W'(a_w);
				sat_q   <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PI controller with clamped error and anti-windup.
module tb;

	localparam int GAIN_DIV     = 100;
	localparam int INTEG_SCALE  = 3;
	localparam int NUM_PROBES   = 25;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 80;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [9:0] drive;
		logic       sat;
	} ctrl_word_t;

	typedef struct packed {
		logic       set_gains;
		logic [7:0] kp;
		logic [7:0] ki;
		logic [9:0] sp;
		logic [9:0] pv;
		logic       known;
		ctrl_word_t word;
	} probe_row_t;

	localparam probe_row_t PROBE_ROWS [NUM_PROBES] = '{
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd0,    1'b1, '{10'd10,  1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd1023, 10'd0,    1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd1023, 1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd500,  10'd0,    1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd501,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd512,  10'd512,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd1023, 10'd1023, 1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd341,  10'd682,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd682,  10'd341,  1'b0, '{10'd0,   1'b0}},
		'{1'b1, 8'd255, 8'd255, 10'd1023, 10'd0,    1'b1, '{10'd900, 1'b1}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd1023, 1'b1, '{10'd0,   1'b1}},
		'{1'b0, 8'd0,   8'd0,   10'd1023, 10'd0,    1'b1, '{10'd900, 1'b1}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd1023, 1'b1, '{10'd0,   1'b1}},
		'{1'b0, 8'd0,   8'd0,   10'd100,  10'd99,   1'b0, '{10'd0,   1'b0}},
		'{1'b1, 8'd0,   8'd255, 10'd10,   10'd0,    1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd10,   1'b0, '{10'd0,   1'b0}},
		'{1'b1, 8'd0,   8'd0,   10'd700,  10'd200,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd1023, 1'b0, '{10'd0,   1'b0}},
		'{1'b1, 8'd37,  8'd200, 10'd0,    10'd600,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd0,    10'd600,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd600,  10'd0,    1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd450,  10'd400,  1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd400,  10'd450,  1'b0, '{10'd0,   1'b0}},
		'{1'b1, 8'd128, 8'd1,   10'd1,    10'd0,    1'b0, '{10'd0,   1'b0}},
		'{1'b0, 8'd0,   8'd0,   10'd1022, 10'd1,    1'b0, '{10'd0,   1'b0}}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_wr_en;
	logic [0:0]                         cfg_index;
	logic [pica_pkg::GAIN_W-1:0]        cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic [pica_pkg::SAMPLE_W-1:0]      setpoint;
	logic [pica_pkg::SAMPLE_W-1:0]      process_value;
	logic                               out_valid;
	logic                               out_ready;
	logic [pica_pkg::SAMPLE_W-1:0]      drive;
	logic                               saturated;

	logic [7:0]  prop_gain_m;
	logic [7:0]  integ_gain_m;
	int          integ_acc_m;
	ctrl_word_t  pending_q [$];
	ctrl_word_t  model_word;
	ctrl_word_t  want_word;
	logic        tag_known;
	ctrl_word_t  tag_word;
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned checked_cnt = 0;
	int unsigned sat_cnt = 0;
	int unsigned sent_cnt = 0;
	int unsigned setting_cnt = 1;
	int unsigned cycle_cnt = 0;

	pi_controller_anti_windup i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.setpoint      (setpoint),
		.process_value (process_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.saturated     (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic ctrl_word_t step_controller(input logic [9:0] sp, input logic [9:0] pv);
		int err;
		int p_term;
		int i_term;
		int total;
		ctrl_word_t res;
		err = int'(sp) - int'(pv);
		if (err > int'(pica_pkg::ERR_MAX))
			err = int'(pica_pkg::ERR_MAX);
		if (err < int'(pica_pkg::ERR_MIN))
			err = int'(pica_pkg::ERR_MIN);
		p_term = (err * int'(prop_gain_m)) / GAIN_DIV;
		i_term = (int'(integ_gain_m) * err * INTEG_SCALE) / GAIN_DIV + integ_acc_m;
		total = p_term + i_term;
		if (total > int'(pica_pkg::DRIVE_MAX)) begin
			integ_acc_m = int'(pica_pkg::DRIVE_MAX) - p_term;
			res = '{10'(pica_pkg::DRIVE_MAX), 1'b1};
		end else if (total < 0) begin
			integ_acc_m = 0 - p_term;
			res = '{10'd0, 1'b1};
		end else begin
			integ_acc_m = i_term;
			res = '{10'(total), 1'b0};
		end
		return res;
	endfunction

	function automatic logic [9:0] fit_sample(input int v);
		if (v < 0)
			return 10'd0;
		if (v > 1023)
			return 10'd1023;
		return 10'(v);
	endfunction

	task automatic report_mismatch(input string what, input ctrl_word_t want);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t %s: expected drive=%0d saturated=%0b, got drive=%0d saturated=%0b",
				$time, what, want.drive, want.sat, drive, saturated);
	endtask

	task automatic load_gains(input logic [7:0] kp, input logic [7:0] ki);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= pica_pkg::REG_PROP_GAIN;
		cfg_data  <= kp;
		@(posedge clk);
		cfg_index <= pica_pkg::REG_INTEG_GAIN;
		cfg_data  <= ki;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		prop_gain_m  = kp;
		integ_gain_m = ki;
		setting_cnt++;
	endtask

	task automatic offer_sample(input logic [9:0] sp, input logic [9:0] pv,
		input logic known, input ctrl_word_t word);
		while (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		setpoint      <= sp;
		process_value <= pv;
		tag_known     <= known;
		tag_word      <= word;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	// hold off on request, otherwise stall at random while idle_on is set
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(99) < 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			model_word = step_controller(setpoint, process_value);
			pending_q.push_back(tag_known ? tag_word : model_word);
			sent_cnt++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("word with nothing pending", '0);
			end else begin
				want_word = pending_q.pop_front();
				checked_cnt++;
				if (saturated === 1'b1)
					sat_cnt++;
				if (drive !== want_word.drive || saturated !== want_word.sat)
					report_mismatch("field mismatch", want_word);
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("** pi_controller_anti_windup: FAILED **");
		$finish;
	end

	initial begin
		int phase;
		int k;
		int mode;
		int base;
		int off;
		logic [7:0] kp;
		logic [7:0] ki;
		logic [9:0] sp;
		logic [9:0] pv;
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= pica_pkg::REG_PROP_GAIN;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		setpoint      <= '0;
		process_value <= '0;
		out_ready     <= 1'b0;
		tag_known     <= 1'b0;
		tag_word      <= '0;
		prop_gain_m   = pica_pkg::GAIN_RESET;
		integ_gain_m  = pica_pkg::GAIN_RESET;
		integ_acc_m   = int'(pica_pkg::ACC_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NUM_PROBES; k++) begin
			if (PROBE_ROWS[k].set_gains)
				load_gains(PROBE_ROWS[k].kp, PROBE_ROWS[k].ki);
			offer_sample(PROBE_ROWS[k].sp, PROBE_ROWS[k].pv, PROBE_ROWS[k].known,
				PROBE_ROWS[k].word);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					kp = 8'd0;
					ki = 8'd0;
				end
				1: begin
					kp = 8'd255;
					ki = 8'd255;
				end
				2: begin
					kp = pica_pkg::GAIN_RESET;
					ki = pica_pkg::GAIN_RESET;
				end
				3: begin
					kp = 8'd255;
					ki = 8'd0;
				end
				4: begin
					kp = 8'd0;
					ki = 8'd255;
				end
				default: begin
					kp = 8'($urandom_range(255));
					ki = 8'($urandom_range(255));
				end
			endcase
			load_gains(kp, ki);
			idle_on = (phase != 3);
			for (k = 0; k < PHASE_WORDS; k++) begin
				if (phase == 5 && k == 20)
					hold_req = 1'b1;
				mode = $urandom_range(99);
				base = $urandom_range(1023);
				if (mode < 45) begin
					// track: measured value close to setpoint
					off = int'($urandom_range(80)) - 40;
					sp  = 10'(base);
					pv  = fit_sample(base + off);
				end else if (mode < 70) begin
					sp = 10'(base);
					pv = 10'($urandom_range(1023));
				end else if (mode < 85) begin
					sp = $urandom_range(1) ? 10'd1023 : 10'd0;
					pv = ($urandom_range(2) == 0) ? 10'(base) :
						($urandom_range(1) ? 10'd1023 : 10'd0);
				end else begin
					// straddle the error clamp
					off = int'($urandom_range(505, 495));
					if ($urandom_range(1)) begin
						sp = 10'(base);
						pv = fit_sample(base - off);
					end else begin
						pv = 10'(base);
						sp = fit_sample(base - off);
					end
				end
				offer_sample(sp, pv, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		idle_on = 1'b1;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d samples over %0d gain settings, %0d results checked, %0d saturated",
			sent_cnt, setting_cnt, checked_cnt, sat_cnt);
		$display("Summary: clamp, windup and backpressure cases driven; %0d mismatches",
			mismatch_cnt);
		if (mismatch_cnt == 0 && pending_q.size() == 0)
			$display("** pi_controller_anti_windup: PASSED **");
		else
			$display("** pi_controller_anti_windup: FAILED **");
		$finish;
	end

endmodule
